// ===== rtl/bbe_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared types, widths and fixed-point log helpers for the byte entropy block.
// ----------------------------------------------------------------------------
package bbe_pkg;

   localparam int BINS          = 256;
   localparam int BYTE_W        = 8;
   localparam int LEN_W         = 9;
   localparam int ENT_W         = 16;
   localparam int MAX_BLOCK_DEF = 256;
   localparam int LOG_FRAC      = 20;
   localparam int RESET_LEN     = 16;
   localparam int ENT_SAT       = 32768;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_WAIT,
      ST_NUM,
      ST_DIV,
      ST_OUT
   } bbe_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bbe_div_stat_type;

   // log2(x), LOG_FRAC fraction bits; elaboration use only
   function automatic logic [63:0] log2_fix(input logic [31:0] x);
      logic [63:0] y;
      logic [63:0] r;
      int          n;
      n = 0;
      y = '0;
      r = '0;
      if (x != 0) begin
         for (int i = 0; i < 31; i++) begin
            if ((x >> (i + 1)) != 0) n = i + 1;
         end
         y = {32'd0, x} << (30 - n);
         r = 64'(n);
         for (int i = 0; i < LOG_FRAC; i++) begin
            y = (y * y) >> 30;
            r = r << 1;
            if (y >= (64'd1 << 31)) begin
               r = r | 64'd1;
               y = y >> 1;
            end
         end
      end
      return r;
   endfunction

   // c*log2(c), Q12, rounded half up
   function automatic logic [63:0] clog_q12(input logic [31:0] c);
      logic [63:0] v;
      v = '0;
      if (c > 1) v = ({32'd0, c} * log2_fix(c) + 64'd128) >> 8;
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/bbe_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_req_if
// Request channel: one stream byte plus end-of-data flag.
// ----------------------------------------------------------------------------
interface bbe_req_if;
   logic                      valid;
   logic                      ready;
   logic [bbe_pkg::BYTE_W-1:0] data_byte;
   logic                      end_of_data;

   modport source (output valid, output data_byte, output end_of_data, input ready);
   modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbe_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_rsp_if
// Response channel: block entropy (Q12) and block length.
// ----------------------------------------------------------------------------
interface bbe_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [bbe_pkg::ENT_W-1:0] entropy_q12;
   logic [bbe_pkg::LEN_W-1:0] block_length;

   modport source (output valid, output entropy_q12, output block_length, input ready);
   modport sink   (input valid, input entropy_q12, input block_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/bbe_hist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_hist
// Histogram memory with read-modify-write, forwarding and running c*log2(c) sum.
// ----------------------------------------------------------------------------
module bbe_hist #(
   parameter int MAX_BLOCK = bbe_pkg::MAX_BLOCK_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_req,
   input  wire logic [bbe_pkg::BYTE_W-1:0] wr_byte,
   input  wire logic                       blk_clear,
   output logic [$clog2(MAX_BLOCK*$clog2(MAX_BLOCK)*4096+1)-1:0] wsum
);
   import bbe_pkg::*;

   localparam int CW   = $clog2(MAX_BLOCK + 1);
   localparam int IW   = $clog2(MAX_BLOCK);
   localparam int WSW  = $clog2(MAX_BLOCK * $clog2(MAX_BLOCK) * 4096 + 1);

   typedef logic [MAX_BLOCK-1:0][WSW-1:0] delta_tab_type;

   function automatic delta_tab_type build_delta();
      delta_tab_type t;
      for (int c = 0; c < MAX_BLOCK; c++) begin
         t[c] = WSW'(clog_q12(32'(c + 1)) - clog_q12(32'(c)));
      end
      return t;
   endfunction

   localparam delta_tab_type DELTA = build_delta();

   logic [CW:0]          mem [BINS];
   logic [BINS-1:0]      vld_ff;
   logic [CW:0]          rd_ff;
   logic                 s1_ff;
   logic [BYTE_W-1:0]    s1_byte_ff;
   logic                 fwd_ff;
   logic [BYTE_W-1:0]    fwd_addr_ff;
   logic [CW-1:0]        fwd_cnt_ff;
   logic                 epoch_ff;
   logic                 epoch_in;
   logic [WSW-1:0]       ws_ff;
   logic [WSW-1:0]       ws_in;
   logic [CW-1:0]        cnt;
   logic [CW-1:0]        cnt_inc;

   always_comb begin
      if (fwd_ff && fwd_addr_ff == s1_byte_ff) begin
         cnt = fwd_cnt_ff;
      end else if (vld_ff[s1_byte_ff] && rd_ff[CW] == epoch_ff) begin
         cnt = rd_ff[CW-1:0];
      end else begin
         cnt = '0;
      end
      cnt_inc = cnt + CW'(1);
   end

   always_comb begin
      ws_in    = ws_ff;
      epoch_in = epoch_ff;
      if (blk_clear) begin
         ws_in    = '0;
         epoch_in = ~epoch_ff;
      end else if (s1_ff) begin
         ws_in = ws_ff + DELTA[cnt[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req) rd_ff <= mem[wr_byte];
      if (s1_ff) mem[s1_byte_ff] <= {epoch_ff, cnt_inc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         s1_ff    <= 1'b0;
         fwd_ff   <= 1'b0;
         epoch_ff <= 1'b0;
         ws_ff    <= '0;
      end else begin
         s1_ff    <= wr_req;
         fwd_ff   <= s1_ff;
         epoch_ff <= epoch_in;
         ws_ff    <= ws_in;
         if (blk_clear) vld_ff <= '0;
         else if (s1_ff) vld_ff[s1_byte_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_req) s1_byte_ff <= wr_byte;
      if (s1_ff) begin
         fwd_addr_ff <= s1_byte_ff;
         fwd_cnt_ff  <= cnt_inc;
      end
   end

   assign wsum = ws_ff;

endmodule
`default_nettype wire

// ===== rtl/bbe_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bbe_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbe_div #(
   parameter int DW = 25,
   parameter int VW = 9
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DW-1:0]        dividend,
   input  wire logic [VW-1:0]        divisor,
   output bbe_pkg::bbe_div_stat_type stat,
   output logic [DW-1:0]             quotient
);
   import bbe_pkg::*;

   localparam int NW = $clog2(DW + 1);

   logic [DW-1:0] dvd_ff;
   logic [DW-1:0] quo_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] dsr_ff;
   logic [NW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   trial;
   logic          take;

   always_comb begin
      trial = {rem_ff, dvd_ff[DW-1]};
      take  = trial >= {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= NW'(DW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         quo_ff <= {quo_ff[DW-2:0], take};
         rem_ff <= take ? VW'(trial - {1'b0, dsr_ff}) : trial[VW-1:0];
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/block_byte_entropy_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// block_byte_entropy_top
// Per-block Shannon entropy of a byte stream.
//
// req: valid/ready stream of data_byte with end_of_data marking the last byte.
// rsp: valid/ready stream of entropy_q12 (bits, Q12) and block_length.
// csr: csr_wr_en/csr_wr_data writes the block length (0 acts as 1, values
//      above MAX_BLOCK act as MAX_BLOCK); write only while the block is idle.
// Bytes inside a block are taken one per cycle; the histogram memory is
// read into a register as a request is accepted and written back in the
// cycle after, with the last written bin forwarded so repeated bytes do
// not stall. The byte that closes a block (full length or end_of_data) is
// followed by a quiet period in which the sum is finished (ST_WAIT), the
// numerator is formed (ST_NUM), the serial divider runs (ST_DIV) and the
// response register is loaded (ST_OUT); ST_DIV is skipped when the
// numerator is not positive. req.ready is low meanwhile.
// If the receiver stalls, the result waits in the response register and
// the next block cannot close until it is taken.
// Reset and every block close empty the histogram through per-bin valid
// bits at once; reset returns the block length to 16.
// ----------------------------------------------------------------------------
module block_byte_entropy_top #(
   parameter int MAX_BLOCK = bbe_pkg::MAX_BLOCK_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   bbe_req_if.sink                        req,
   bbe_rsp_if.source                      rsp,
   input  wire logic                      csr_wr_en,
   input  wire logic [bbe_pkg::LEN_W-1:0] csr_wr_data
);
   import bbe_pkg::*;

   localparam int    CW     = $clog2(MAX_BLOCK + 1);
   localparam int    LOGB   = $clog2(MAX_BLOCK);
   localparam int    WSW    = $clog2(MAX_BLOCK * LOGB * 4096 + 1);
   localparam longint NLMAX = longint'(MAX_BLOCK) * longint'(LOGB) * (longint'(1) << 20);
   localparam int    NLW    = $clog2(NLMAX + 1);
   localparam int    DW     = NLW + 1 - 8;

   typedef logic [MAX_BLOCK:0][NLW-1:0] nl_tab_type;

   function automatic nl_tab_type build_nl();
      nl_tab_type t;
      for (int n = 0; n <= MAX_BLOCK; n++) begin
         t[n] = NLW'(64'(n) * log2_fix(32'(n)));
      end
      return t;
   endfunction

   localparam nl_tab_type NL = build_nl();

   bbe_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  len_ff;
   logic [CW-1:0]     pos_ff;
   logic [CW-1:0]     n_ff;
   logic [CW-1:0]     eff_len;
   logic [CW:0]       pos_inc;
   logic              req_acc;
   logic              close;
   logic [WSW-1:0]    wsum;
   logic [NLW:0]      num_pos;
   logic [NLW:0]      num_neg;
   logic [NLW:0]      dvd_full;
   logic              num_gt0;
   logic              div_start;
   logic              fire;
   bbe_div_stat_type  div_stat;
   logic [DW-1:0]     quo;
   logic [ENT_W-1:0]  q_ff;
   logic              rsp_vld_ff;
   logic [ENT_W-1:0]  rsp_ent_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   always_comb begin
      if (int'(len_ff) > MAX_BLOCK) eff_len = CW'(MAX_BLOCK);
      else if (len_ff == '0)        eff_len = CW'(1);
      else                          eff_len = CW'(len_ff);
      pos_inc = {1'b0, pos_ff} + (CW + 1)'(1);
      req_acc = req.valid && req.ready;
      close   = req.end_of_data || (pos_inc >= {1'b0, eff_len});
   end

   always_comb begin
      num_pos  = {1'b0, NL[n_ff]};
      num_neg  = (NLW + 1)'({wsum, 8'd0});
      num_gt0  = num_pos > num_neg;
      dvd_full = num_pos + (NLW + 1)'({n_ff, 7'd0}) - num_neg;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:  if (req_acc && close) state_in = ST_WAIT;
         ST_WAIT: state_in = ST_NUM;
         ST_NUM:  state_in = num_gt0 ? ST_DIV : ST_OUT;
         ST_DIV:  if (div_stat.done) state_in = ST_OUT;
         ST_OUT:  if (!rsp_vld_ff || rsp.ready) state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      div_start = 1'b0;
      fire      = 1'b0;
      unique case (state_ff)
         ST_RUN:  req.ready = 1'b1;
         ST_NUM:  div_start = num_gt0;
         ST_OUT:  fire = !rsp_vld_ff || rsp.ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         len_ff     <= LEN_W'(RESET_LEN);
         pos_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) len_ff <= csr_wr_data;
         if (req_acc) pos_ff <= close ? '0 : pos_inc[CW-1:0];
         if (fire)                 rsp_vld_ff <= 1'b1;
         else if (rsp.ready)       rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) n_ff <= pos_inc[CW-1:0];
      if (state_ff == ST_NUM && !num_gt0) q_ff <= '0;
      if (div_stat.done) begin
         q_ff <= (quo > DW'(ENT_SAT)) ? ENT_W'(ENT_SAT) : quo[ENT_W-1:0];
      end
      if (fire) begin
         rsp_ent_ff <= q_ff;
         rsp_len_ff <= LEN_W'(n_ff);
      end
   end

   bbe_hist #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_hist (
      .clock     (clock),
      .reset     (reset),
      .wr_req    (req_acc),
      .wr_byte   (req.data_byte),
      .blk_clear (fire),
      .wsum      (wsum)
   );

   bbe_div #(
      .DW (DW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dvd_full[NLW:8]),
      .divisor  (n_ff),
      .stat     (div_stat),
      .quotient (quo)
   );

   assign rsp.valid        = rsp_vld_ff;
   assign rsp.entropy_q12  = rsp_ent_ff;
   assign rsp.block_length = rsp_len_ff;

endmodule
`default_nettype wire
